### design/rtbc_pkg.sv
// Shared types, constants and timeout word helpers for the timing budget calculator.
`timescale 1ns / 1ps

package rtbc_pkg;

  // Macro period: (K1 * pclks * K2 + 500) / 1000 ns
  localparam int unsigned MACRO_K1  = 2304;
  localparam int unsigned MACRO_K2  = 1655;
  localparam int unsigned MACRO_K   = MACRO_K1 * MACRO_K2;
  localparam int unsigned MACRO_RND = 500;
  localparam int unsigned NS_PER_US = 1000;

  // Divide by 1000 as a reciprocal multiply, exact for every 32-bit dividend:
  // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT
  localparam int unsigned        RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP_1000  = 29'd274877907;
  localparam int unsigned        RECIP_SHIFT = 38;

  // Step overheads in microseconds
  localparam int unsigned GET_START_OH  = 1910;
  localparam int unsigned SET_START_OH  = 1320;
  localparam int unsigned END_OH        = 960;
  localparam int unsigned MSRC_OH       = 660;
  localparam int unsigned TCC_OH        = 590;
  localparam int unsigned DSS_OH        = 690;
  localparam int unsigned PRE_OH        = 660;
  localparam int unsigned FINAL_OH      = 550;
  localparam int unsigned MIN_BUDGET_US = 20000;
  localparam logic [31:0] MANT_OVER_MASK = 32'hFFFF_FF00;

  // Sequence enable bit positions
  localparam int unsigned SEQ_MSRC  = 2;
  localparam int unsigned SEQ_DSS   = 3;
  localparam int unsigned SEQ_TCC   = 4;
  localparam int unsigned SEQ_PRE   = 6;
  localparam int unsigned SEQ_FINAL = 7;

  // Datapath widths
  localparam int unsigned MP_W      = 20;  // macro period in ns, max 968532
  localparam int unsigned MUL_B_W   = 22;  // widest second multiplier operand
  localparam int unsigned DIV_W     = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  typedef struct packed {
    logic [7:0]  seq_enables;
    logic [7:0]  msrc_timeout_raw;
    logic [7:0]  pre_vcsel_raw;
    logic [15:0] pre_timeout_raw;
    logic [7:0]  final_vcsel_raw;
    logic [15:0] final_timeout_raw;
    logic [31:0] requested_budget_us;
  } in_req_t;

  typedef struct packed {
    logic [31:0] current_budget_us;
    logic [15:0] new_final_timeout;
    logic        timeout_written;
    logic [1:0]  fit_status;
  } out_res_t;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_LOW = 2'd1,
    STAT_BIG = 2'd2
  } stat_t;

  // Which quantity the shared multiply/divide pass computes
  typedef enum logic [2:0] {
    MSEL_PRE_MP,
    MSEL_FIN_MP,
    MSEL_MSRC_US,
    MSEL_PRE_US,
    MSEL_FIN_US,
    MSEL_REQ
  } msel_t;

  typedef struct packed {
    logic  load;
    logic  mul_en;
    logic  div_start;
    logic  div_step;
    logic  wb_en;
    logic  sum1;
    logic  sum2;
    logic  finish;
    msel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_stat_t;

  // Period register to pclks, wrapping at 8 bits
  function automatic logic [7:0] vcsel_pclks(logic [7:0] raw);
    return {raw[6:0] + 7'd1, 1'b0};
  endfunction

  // Mantissa-exponent timeout word to macro periods, 16-bit wrap
  function automatic logic [15:0] decode_word(logic [15:0] w);
    logic [15:0] m;
    m = '0;
    if (w[15:8] < 8'd16) begin
      m = 16'(w[7:0]) << w[11:8];
    end
    return m + 16'd1;
  endfunction

  // Macro periods to mantissa-exponent word; at most eight shifts
  function automatic logic [15:0] encode_word(logic [15:0] m);
    logic [15:0] ls;
    logic [7:0]  ms;
    ls = m - 16'd1;
    ms = '0;
    for (int i = 0; i < 8; i++) begin
      if ((ls & MANT_OVER_MASK[15:0]) != '0) begin
        ls = ls >> 1;
        ms = ms + 8'd1;
      end
    end
    if (m == '0) begin
      return '0;
    end
    return {ms, ls[7:0]};
  endfunction

endpackage

### design/rtbc_datapath.sv
// Datapath: operand registers, shared multiplier, reciprocal divide, serial divider, sums, result.
`timescale 1ns / 1ps

module rtbc_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  rtbc_pkg::dp_cmd_t cmd,
  input  rtbc_pkg::in_req_t in_req,
  output rtbc_pkg::dp_stat_t stat,
  output logic              out_valid,
  output rtbc_pkg::out_res_t out_res
);

  localparam int unsigned MP_W  = rtbc_pkg::MP_W;
  localparam int unsigned MB_W  = rtbc_pkg::MUL_B_W;
  localparam int unsigned DIV_W = rtbc_pkg::DIV_W;
  localparam int unsigned CNT_W = rtbc_pkg::DIV_CNT_W;
  localparam int unsigned RC_W  = rtbc_pkg::RECIP_W;

  rtbc_pkg::in_req_t  in_r;
  logic [15:0]        pre_mclks_r;
  logic [15:0]        fin_mclks_r;
  logic [MP_W-1:0]    pre_mp_r;
  logic [MP_W-1:0]    fin_mp_r;
  logic [31:0]        msrc_us_r;
  logic [31:0]        pre_us_r;
  logic [31:0]        fin_us_r;
  logic [31:0]        num_r;
  logic [DIV_W-1:0]   rem_r;
  logic [DIV_W-1:0]   quo_r;
  logic [DIV_W-1:0]   dsr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [31:0]        steps_r;
  logic [31:0]        cur_r;
  logic [31:0]        diff_r;
  logic               ovr_r;
  logic               out_valid_r;
  rtbc_pkg::out_res_t out_res_r;

  logic               en_tcc, en_dss, en_msrc, en_pre, en_fin;
  logic [31:0]        mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [31:0]        mul_add;
  logic [31+MB_W:0]   mul_full;
  logic [31:0]        num_nxt;
  logic [31+RC_W:0]   rcp_full;
  logic [31:0]        quo_k;
  logic [DIV_W:0]     trial;
  logic               trial_ge;
  logic [DIV_W-1:0]   rem_nxt;
  logic [15:0]        pre_dec, fin_dec;
  logic [31:0]        t_tcc, t_dm, t_pre, t_fin, used;
  logic [15:0]        m_req;
  rtbc_pkg::out_res_t res_nxt;

  assign en_tcc  = in_r.seq_enables[rtbc_pkg::SEQ_TCC];
  assign en_dss  = in_r.seq_enables[rtbc_pkg::SEQ_DSS];
  assign en_msrc = in_r.seq_enables[rtbc_pkg::SEQ_MSRC];
  assign en_pre  = in_r.seq_enables[rtbc_pkg::SEQ_PRE];
  assign en_fin  = in_r.seq_enables[rtbc_pkg::SEQ_FINAL];

  // Decode timeout words straight from the incoming request
  assign pre_dec = rtbc_pkg::decode_word(in_req.pre_timeout_raw);
  assign fin_dec = rtbc_pkg::decode_word(in_req.final_timeout_raw);

  // Select multiplier operands for the current pass
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_add = '0;
    unique case (cmd.sel)
      rtbc_pkg::MSEL_PRE_MP: begin
        mul_a   = 32'(rtbc_pkg::vcsel_pclks(in_r.pre_vcsel_raw));
        mul_b   = MB_W'(rtbc_pkg::MACRO_K);
        mul_add = 32'(rtbc_pkg::MACRO_RND);
      end
      rtbc_pkg::MSEL_FIN_MP: begin
        mul_a   = 32'(rtbc_pkg::vcsel_pclks(in_r.final_vcsel_raw));
        mul_b   = MB_W'(rtbc_pkg::MACRO_K);
        mul_add = 32'(rtbc_pkg::MACRO_RND);
      end
      rtbc_pkg::MSEL_MSRC_US: begin
        mul_a   = 32'({1'b0, in_r.msrc_timeout_raw} + 9'd1);
        mul_b   = MB_W'(pre_mp_r);
        mul_add = 32'(pre_mp_r >> 1);
      end
      rtbc_pkg::MSEL_PRE_US: begin
        mul_a   = 32'(pre_mclks_r);
        mul_b   = MB_W'(pre_mp_r);
        mul_add = 32'(pre_mp_r >> 1);
      end
      rtbc_pkg::MSEL_FIN_US: begin
        mul_a   = 32'(fin_mclks_r);
        mul_b   = MB_W'(fin_mp_r);
        mul_add = 32'(fin_mp_r >> 1);
      end
      rtbc_pkg::MSEL_REQ: begin
        mul_a   = diff_r;
        mul_b   = MB_W'(rtbc_pkg::NS_PER_US);
        mul_add = 32'(fin_mp_r >> 1);
      end
      default: begin
      end
    endcase
  end

  assign mul_full = (32 + MB_W)'(mul_a) * (32 + MB_W)'(mul_b);
  assign num_nxt  = mul_full[31:0] + mul_add;

  // Divide the held product by 1000 with the reciprocal multiply
  assign rcp_full = (32 + RC_W)'(num_r) * (32 + RC_W)'(rtbc_pkg::RECIP_1000);
  assign quo_k    = 32'(rcp_full[31+RC_W:rtbc_pkg::RECIP_SHIFT]);

  // One restoring divide step: shift in next dividend bit, trial subtract
  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign trial_ge = trial >= {1'b0, dsr_r};
  assign rem_nxt  = trial_ge ? DIV_W'(trial - {1'b0, dsr_r}) : trial[DIV_W-1:0];

  assign stat.div_last = (cnt_r == '1);

  // Step terms for the budget sums; the final-range term counts only in the current budget
  assign t_tcc = en_tcc ? msrc_us_r + 32'(rtbc_pkg::TCC_OH) : '0;
  assign t_dm  = en_dss  ? (msrc_us_r + 32'(rtbc_pkg::DSS_OH)) << 1 :
                 en_msrc ? msrc_us_r + 32'(rtbc_pkg::MSRC_OH) : '0;
  assign t_pre = en_pre ? pre_us_r + 32'(rtbc_pkg::PRE_OH) : '0;
  assign t_fin = en_fin ? fin_us_r + 32'(rtbc_pkg::FINAL_OH) : '0;
  assign used  = steps_r + 32'(rtbc_pkg::SET_START_OH + rtbc_pkg::END_OH
                               + rtbc_pkg::FINAL_OH);

  // Build the result from the last quotient
  assign m_req = quo_r[15:0] + (en_pre ? pre_mclks_r : 16'd0);

  always_comb begin
    res_nxt                   = '0;
    res_nxt.current_budget_us = cur_r;
    if (in_r.requested_budget_us < 32'(rtbc_pkg::MIN_BUDGET_US)) begin
      res_nxt.fit_status = rtbc_pkg::STAT_LOW;
    end else if (en_fin) begin
      if (ovr_r) begin
        res_nxt.fit_status = rtbc_pkg::STAT_BIG;
      end else begin
        res_nxt.new_final_timeout = rtbc_pkg::encode_word(m_req);
        res_nxt.timeout_written   = 1'b1;
        res_nxt.fit_status        = rtbc_pkg::STAT_OK;
      end
    end
  end

  // Hold operands and intermediate results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r        <= in_req;
      pre_mclks_r <= pre_dec;
      fin_mclks_r <= fin_dec - (in_req.seq_enables[rtbc_pkg::SEQ_PRE] ? pre_dec : 16'd0);
    end
    if (cmd.mul_en) begin
      num_r <= num_nxt;
    end
    // only the requested-budget pass divides; a zero period gives all ones
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= num_r;
      dsr_r <= DIV_W'(fin_mp_r);
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], trial_ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.wb_en) begin
      unique case (cmd.sel)
        rtbc_pkg::MSEL_PRE_MP:  pre_mp_r  <= quo_k[MP_W-1:0];
        rtbc_pkg::MSEL_FIN_MP:  fin_mp_r  <= quo_k[MP_W-1:0];
        rtbc_pkg::MSEL_MSRC_US: msrc_us_r <= quo_k;
        rtbc_pkg::MSEL_PRE_US:  pre_us_r  <= quo_k;
        rtbc_pkg::MSEL_FIN_US:  fin_us_r  <= quo_k;
        default: begin
        end
      endcase
    end
    if (cmd.sum1) begin
      steps_r <= t_tcc + t_dm + t_pre;
    end
    if (cmd.sum2) begin
      cur_r  <= steps_r + t_fin + 32'(rtbc_pkg::GET_START_OH + rtbc_pkg::END_OH);
      ovr_r  <= used > in_r.requested_budget_us;
      diff_r <= in_r.requested_budget_us - used;
    end
    if (cmd.finish) begin
      out_res_r <= res_nxt;
    end
  end

  // Strobe the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_written_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.timeout_written |-> out_res_r.fit_status == rtbc_pkg::STAT_OK)
    else $error("timeout written with error status");

  a_err_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.fit_status != rtbc_pkg::STAT_OK |->
      out_res_r.new_final_timeout == '0 && !out_res_r.timeout_written)
    else $error("error result carries a timeout word");

  a_div_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step && !cmd.div_start && stat.div_last |=> cnt_r == '0)
    else $error("divider step count did not wrap after last step");

endmodule

### design/rtbc_ctrl.sv
// Controller: sequences the multiply/divide passes, the sums and the result.
`timescale 1ns / 1ps

module rtbc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rtbc_pkg::dp_stat_t stat,
  output rtbc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIVL,
    S_DIV,
    S_WB,
    S_SUM1,
    S_SUM2,
    S_DONE
  } state_t;

  state_t              state_r;
  rtbc_pkg::msel_t     sel_r;
  logic                busy_r;

  // Decode datapath commands from the state
  always_comb begin
    cmd     = '0;
    cmd.sel = sel_r;
    unique case (state_r)
      S_IDLE: cmd.load      = start && !busy_r;
      S_MUL:  cmd.mul_en    = 1'b1;
      S_DIVL: cmd.div_start = 1'b1;
      S_DIV:  cmd.div_step  = 1'b1;
      S_WB:   cmd.wb_en     = 1'b1;
      S_SUM1: cmd.sum1      = 1'b1;
      S_SUM2: cmd.sum2      = 1'b1;
      S_DONE: cmd.finish    = 1'b1;
      default: begin
      end
    endcase
  end

  // Advance through the passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= rtbc_pkg::MSEL_PRE_MP;
      busy_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start && !busy_r) begin
            state_r <= S_MUL;
            sel_r   <= rtbc_pkg::MSEL_PRE_MP;
            busy_r  <= 1'b1;
          end
        end
        // only the requested-budget pass needs the serial divider
        S_MUL: begin
          priority if (sel_r == rtbc_pkg::MSEL_REQ) begin
            state_r <= S_DIVL;
          end else begin
            state_r <= S_WB;
          end
        end
        S_DIVL: state_r <= S_DIV;
        S_DIV: begin
          if (stat.div_last) begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          priority if (sel_r == rtbc_pkg::MSEL_FIN_US) begin
            state_r <= S_SUM1;
          end else if (sel_r == rtbc_pkg::MSEL_REQ) begin
            state_r <= S_DONE;
          end else begin
            sel_r   <= rtbc_pkg::msel_t'(sel_r + 3'd1);
            state_r <= S_MUL;
          end
        end
        S_SUM1: state_r <= S_SUM2;
        S_SUM2: begin
          sel_r   <= rtbc_pkg::MSEL_REQ;
          state_r <= S_MUL;
        end
        S_DONE: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy = busy_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy_r |=> state_r == S_MUL && sel_r == rtbc_pkg::MSEL_PRE_MP && busy_r)
    else $error("accepted request did not start the first pass");

  a_req_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WB && sel_r == rtbc_pkg::MSEL_REQ |=> state_r == S_DONE)
    else $error("last pass did not lead to result");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !busy_r && state_r == S_IDLE)
    else $error("block stayed busy after result");

endmodule

### design/ranging_timing_budget_calc.sv
// Top level of the ranging timing budget calculator.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. The result appears
// on out_res with out_valid high for exactly one cycle; it cannot be held
// off, so capture it on that strobe. busy is high from the accepting edge
// until the strobe cycle, so no new request is taken while one is in work.
// The work is five passes that divide by 1000 with a reciprocal multiply
// (a multiply and a write-back each), two summing states, one pass through
// the radix-2 divider for the requested budget (a multiply, a load, 32 divide
// steps and a write-back), and a result state.

module ranging_timing_budget_calc (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rtbc_pkg::in_req_t  in_req,
  output logic               out_valid,
  output rtbc_pkg::out_res_t out_res
);

  rtbc_pkg::dp_cmd_t  cmd;
  rtbc_pkg::dp_stat_t stat;

  rtbc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rtbc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .stat      (stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

### test/tb.sv
// Self-checking testbench for the ranging timing budget calculator.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 250;
  localparam int unsigned RANDOM_BLOCKS  = 33;
  localparam int unsigned BLOCK_REQUESTS = 25;

  // Sequence enable masks
  localparam logic [7:0] EN_MSRC  = 8'(1 << rtbc_pkg::SEQ_MSRC);
  localparam logic [7:0] EN_DSS   = 8'(1 << rtbc_pkg::SEQ_DSS);
  localparam logic [7:0] EN_TCC   = 8'(1 << rtbc_pkg::SEQ_TCC);
  localparam logic [7:0] EN_PRE   = 8'(1 << rtbc_pkg::SEQ_PRE);
  localparam logic [7:0] EN_FINAL = 8'(1 << rtbc_pkg::SEQ_FINAL);
  localparam logic [7:0] EN_ALL   = EN_MSRC | EN_DSS | EN_TCC | EN_PRE | EN_FINAL;

  // Period register values that give zero pclks
  localparam logic [7:0] VCSEL_ZERO_LO = 8'd127;
  localparam logic [7:0] VCSEL_ZERO_HI = 8'd255;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  rtbc_pkg::in_req_t  in_req;
  logic               out_valid;
  rtbc_pkg::out_res_t out_res;

  rtbc_pkg::out_res_t expected_budgets[$];
  rtbc_pkg::out_res_t want;
  int unsigned accepted_count = 0;
  int unsigned result_count   = 0;
  int unsigned written_count  = 0;
  int unsigned low_count      = 0;
  int unsigned big_count      = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;

  ranging_timing_budget_calc i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always #2 clk = ~clk;

  // Macro period in ns for a period register; pclks wrap at 8 bits
  function automatic logic [31:0] period_ns_of(logic [7:0] raw);
    logic [31:0] pclks;
    pclks = ((32'(raw) + 32'd1) << 1) & 32'hFF;
    return (rtbc_pkg::MACRO_K1 * pclks * rtbc_pkg::MACRO_K2 + 32'd500) / 32'd1000;
  endfunction

  function automatic logic [31:0] mclk_time_us(logic [31:0] mclks, logic [31:0] mp);
    return (mclks * mp + mp / 32'd2) / 32'd1000;
  endfunction

  // Zero period saturates to all ones
  function automatic logic [31:0] budget_to_mclks(logic [31:0] us, logic [31:0] mp);
    if (mp == '0) begin
      return 32'hFFFF_FFFF;
    end
    return (us * 32'd1000 + mp / 32'd2) / mp;
  endfunction

  // Mantissa-exponent word to macro periods; large exponents drop the mantissa
  function automatic logic [15:0] decode_timeout(logic [15:0] w);
    logic [31:0] m;
    m = '0;
    if (w[15:8] < 8'd16) begin
      m = (32'(w[7:0]) << w[15:8]) & 32'hFFFF;
    end
    return 16'(m + 32'd1);
  endfunction

  function automatic logic [15:0] timeout_word(logic [15:0] mclks);
    logic [31:0] ls;
    logic [7:0]  ms;
    ls = 32'(mclks) - 32'd1;
    ms = '0;
    if (mclks == '0) begin
      return '0;
    end
    while ((ls & 32'hFFFF_FF00) != '0) begin
      ls = ls >> 1;
      ms = ms + 8'd1;
    end
    return {ms, ls[7:0]};
  endfunction

  function automatic rtbc_pkg::out_res_t predict_budget(rtbc_pkg::in_req_t r);
    rtbc_pkg::out_res_t res;
    logic        use_tcc, use_dss, use_msrc, use_pre, use_final;
    logic [31:0] pre_mp, fin_mp, msrc_us, pre_us, fin_us, steps, used, mclks32;
    logic [15:0] pre_mclks, fin_mclks, req_mclks;
    use_tcc   = r.seq_enables[rtbc_pkg::SEQ_TCC];
    use_dss   = r.seq_enables[rtbc_pkg::SEQ_DSS];
    use_msrc  = r.seq_enables[rtbc_pkg::SEQ_MSRC];
    use_pre   = r.seq_enables[rtbc_pkg::SEQ_PRE];
    use_final = r.seq_enables[rtbc_pkg::SEQ_FINAL];
    pre_mp    = period_ns_of(r.pre_vcsel_raw);
    fin_mp    = period_ns_of(r.final_vcsel_raw);
    msrc_us   = mclk_time_us(32'(r.msrc_timeout_raw) + 32'd1, pre_mp);
    pre_mclks = decode_timeout(r.pre_timeout_raw);
    pre_us    = mclk_time_us(32'(pre_mclks), pre_mp);
    fin_mclks = decode_timeout(r.final_timeout_raw);
    // final range counts only the part past the pre-range
    if (use_pre) begin
      fin_mclks = fin_mclks - pre_mclks;
    end
    fin_us = mclk_time_us(32'(fin_mclks), fin_mp);

    // sum the enabled steps ahead of the final range; dss replaces msrc
    steps = '0;
    if (use_tcc) begin
      steps = steps + msrc_us + rtbc_pkg::TCC_OH;
    end
    if (use_dss) begin
      steps = steps + 32'd2 * (msrc_us + rtbc_pkg::DSS_OH);
    end else if (use_msrc) begin
      steps = steps + msrc_us + rtbc_pkg::MSRC_OH;
    end
    if (use_pre) begin
      steps = steps + pre_us + rtbc_pkg::PRE_OH;
    end

    res = '0;
    res.fit_status = rtbc_pkg::STAT_OK;
    res.current_budget_us = rtbc_pkg::GET_START_OH + rtbc_pkg::END_OH + steps;
    if (use_final) begin
      res.current_budget_us = res.current_budget_us + fin_us + rtbc_pkg::FINAL_OH;
    end

    // fit the final-range timeout into what is left of the request
    if (r.requested_budget_us < rtbc_pkg::MIN_BUDGET_US) begin
      res.fit_status = rtbc_pkg::STAT_LOW;
    end else if (use_final) begin
      used = rtbc_pkg::SET_START_OH + rtbc_pkg::END_OH + steps + rtbc_pkg::FINAL_OH;
      if (used > r.requested_budget_us) begin
        res.fit_status = rtbc_pkg::STAT_BIG;
      end else begin
        mclks32   = budget_to_mclks(r.requested_budget_us - used, fin_mp);
        req_mclks = mclks32[15:0];
        if (use_pre) begin
          req_mclks = req_mclks + pre_mclks;
        end
        res.new_final_timeout = timeout_word(req_mclks);
        res.timeout_written   = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic rtbc_pkg::in_req_t make_request(logic [7:0] seq, logic [7:0] msrc,
                                                     logic [7:0] pre_v, logic [15:0] pre_t,
                                                     logic [7:0] fin_v, logic [15:0] fin_t,
                                                     logic [31:0] budget);
    rtbc_pkg::in_req_t r;
    r.seq_enables         = seq;
    r.msrc_timeout_raw    = msrc;
    r.pre_vcsel_raw       = pre_v;
    r.pre_timeout_raw     = pre_t;
    r.final_vcsel_raw     = fin_v;
    r.final_timeout_raw   = fin_t;
    r.requested_budget_us = budget;
    return r;
  endfunction

  // Mostly plausible sensor setups, final range usually on; the rest is raw noise
  function automatic rtbc_pkg::in_req_t random_request();
    rtbc_pkg::in_req_t r;
    int unsigned shape;
    int unsigned roll;
    r     = {$urandom, $urandom, $urandom};
    shape = $urandom_range(0, 9);
    roll  = $urandom_range(0, 9);
    if (shape < 8) begin
      r.seq_enables[rtbc_pkg::SEQ_FINAL] = ($urandom_range(0, 9) != 0);
      r.pre_vcsel_raw     = 8'($urandom_range(5, 9));
      r.final_vcsel_raw   = 8'($urandom_range(3, 7));
      r.pre_timeout_raw   = {8'($urandom_range(0, 4)), 8'($urandom)};
      r.final_timeout_raw = {8'($urandom_range(0, 6)), 8'($urandom)};
    end
    if (roll == 0) begin
      r.requested_budget_us = $urandom_range(0, rtbc_pkg::MIN_BUDGET_US - 1);
    end else if (roll == 1) begin
      r.requested_budget_us = $urandom_range(rtbc_pkg::MIN_BUDGET_US,
                                             rtbc_pkg::MIN_BUDGET_US + 50);
    end else if (roll < 8 && shape < 8) begin
      r.requested_budget_us = $urandom_range(rtbc_pkg::MIN_BUDGET_US, 1_000_000);
    end
    return r;
  endfunction

  // Sender pause: zero in bursts, otherwise mostly short with some past a whole pass
  function automatic int unsigned idle_gap(bit bursty);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (bursty || roll < 60) begin
      return 0;
    end
    if (roll < 80) begin
      return $urandom_range(1, 8);
    end
    if (roll < 95) begin
      return $urandom_range(9, 230);
    end
    return $urandom_range(231, 600);
  endfunction

  // Hold the request until taken, then queue its expected result
  task automatic send_request(rtbc_pkg::in_req_t r, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req <= r;
    start  <= 1'b1;
    do begin
      @(posedge clk);
    end while (busy);
    expected_budgets.push_back(predict_budget(r));
    accepted_count++;
  endtask

  task automatic wait_results_done();
    start <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_budgets.size() != 0);
  endtask

  task automatic test_field_extremes();
    send_request(make_request(8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h0000, 32'h0), 0);
    send_request(make_request(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF,
                              32'hFFFF_FFFF), idle_gap(0));
    send_request(make_request(8'hAA, 8'h55, 8'hAA, 16'h55AA, 8'h55, 16'hAA55,
                              32'h5555_AAAA), idle_gap(0));
    send_request(make_request(8'h55, 8'hAA, 8'h55, 16'hAA55, 8'hAA, 16'h55AA,
                              32'hAAAA_5555), idle_gap(0));
    send_request(make_request(EN_ALL, 8'd20, 8'd7, 16'h0103, 8'd5, 16'h0230,
                              32'hFFFF_FFFF), idle_gap(0));
  endtask

  // Each enable alone, then dss with msrc, then all of them
  task automatic test_sequence_steps();
    logic [7:0] masks [7];
    masks = '{EN_TCC, EN_DSS, EN_MSRC, EN_PRE, EN_FINAL, EN_DSS | EN_MSRC, EN_ALL};
    foreach (masks[i]) begin
      send_request(make_request(masks[i], 8'd40, 8'd6, 16'h0096, 8'd4, 16'h0204,
                                32'd33000), idle_gap(0));
    end
  endtask

  task automatic test_special_cases();
    // budget under the minimum, and exactly at it
    send_request(make_request(EN_ALL, 8'd10, 8'd6, 16'h0020, 8'd4, 16'h0110,
                              rtbc_pkg::MIN_BUDGET_US - 1), idle_gap(0));
    send_request(make_request(EN_FINAL, 8'd10, 8'd6, 16'h0020, 8'd4, 16'h0110,
                              rtbc_pkg::MIN_BUDGET_US), idle_gap(0));
    // final range off
    send_request(make_request(EN_PRE | EN_TCC, 8'd30, 8'd6, 16'h0080, 8'd4, 16'h0300,
                              32'd200000), idle_gap(0));
    // steps use up more than the request
    send_request(make_request(EN_ALL, 8'd255, 8'd9, 16'h04FF, 8'd5, 16'h0200,
                              rtbc_pkg::MIN_BUDGET_US), idle_gap(0));
    // zero pclks on the pre-range period
    send_request(make_request(EN_ALL, 8'd50, VCSEL_ZERO_LO, 16'h0150, 8'd4, 16'h0300,
                              32'd80000), idle_gap(0));
    send_request(make_request(EN_ALL, 8'd50, VCSEL_ZERO_HI, 16'h0150, 8'd4, 16'h0300,
                              32'd80000), idle_gap(0));
    // zero pclks on the final-range period
    send_request(make_request(EN_FINAL | EN_TCC, 8'd12, 8'd6, 16'h0040, VCSEL_ZERO_LO,
                              16'h0300, 32'd50000), idle_gap(0));
    send_request(make_request(EN_FINAL, 8'd12, 8'd6, 16'h0040, VCSEL_ZERO_HI,
                              16'h0300, 32'd50000), idle_gap(0));
    // exponent of 16 or more in the timeout words
    send_request(make_request(EN_FINAL | EN_PRE, 8'd5, 8'd6, 16'hFF01, 8'd4, 16'h10FF,
                              32'd40000), idle_gap(0));
    send_request(make_request(EN_FINAL | EN_PRE | EN_MSRC, 8'd5, 8'd7, 16'h1077, 8'd3,
                              16'h8012, 32'd60000), idle_gap(0));
    // requested count wraps to zero and encodes to a zero word
    send_request(make_request(EN_FINAL | EN_PRE, 8'd0, 8'd6, 16'h1000, VCSEL_ZERO_LO,
                              16'h0100, 32'd100000), idle_gap(0));
  endtask

  // Back-to-back requests, then hold off until every result is in
  task automatic test_pause_for_results();
    repeat (2) begin
      repeat (6) send_request(random_request(), 0);
      wait_results_done();
    end
  endtask

  task automatic test_random_traffic();
    bit bursty;
    repeat (RANDOM_BLOCKS) begin
      bursty = ($urandom_range(0, 2) == 0);
      repeat (BLOCK_REQUESTS) send_request(random_request(), idle_gap(bursty));
      if ($urandom_range(0, 3) == 0) begin
        wait_results_done();
      end
    end
  endtask

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      result_count++;
      if (expected_budgets.size() == 0) begin
        $display("%0t: result with nothing pending: %p", $time, out_res);
        mismatch_count++;
      end else begin
        want = expected_budgets.pop_front();
        if (out_res.current_budget_us !== want.current_budget_us) begin
          $display("%0t: current_budget_us expected %0d actual %0d",
                   $time, want.current_budget_us, out_res.current_budget_us);
          mismatch_count++;
        end
        if (out_res.new_final_timeout !== want.new_final_timeout) begin
          $display("%0t: new_final_timeout expected %h actual %h",
                   $time, want.new_final_timeout, out_res.new_final_timeout);
          mismatch_count++;
        end
        if (out_res.timeout_written !== want.timeout_written) begin
          $display("%0t: timeout_written expected %b actual %b",
                   $time, want.timeout_written, out_res.timeout_written);
          mismatch_count++;
        end
        if (out_res.fit_status !== want.fit_status) begin
          $display("%0t: fit_status expected %0d actual %0d",
                   $time, want.fit_status, out_res.fit_status);
          mismatch_count++;
        end
      end
      if (out_res.timeout_written === 1'b1) begin
        written_count++;
      end
      if (out_res.fit_status === rtbc_pkg::STAT_LOW) begin
        low_count++;
      end
      if (out_res.fit_status === rtbc_pkg::STAT_BIG) begin
        big_count++;
      end
    end
  end

  // Drop the run when neither a request nor a result moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result for %0d cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n  <= 1'b0;
    start  <= 1'b0;
    in_req <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_sequence_steps();
    test_special_cases();
    test_pause_for_results();
    test_random_traffic();

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Requests taken: %0d, results checked: %0d, mismatches: %0d",
             accepted_count, result_count, mismatch_count);
    $display("New timeout words: %0d, under minimum: %0d, request too small: %0d",
             written_count, low_count, big_count);
    if (mismatch_count == 0 && expected_budgets.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
